### rtl/core/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// Shared constants and types for the tension/bias Hermite interpolator.
// ----------------------------------------------------------------------------
package htb_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int POSITION_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TENSION = 1'b0,
        CFG_BIAS    = 1'b1
    } t_cfg_reg;

    // Q2.14 coefficient arithmetic
    localparam int WEIGHT_BITS  = CFG_DATA_BITS + 1;
    localparam int COEF_PROD    = 2 * WEIGHT_BITS;
    localparam int COEF_SHIFT   = 15;
    localparam int COEF_BITS    = 18;
    localparam int TENSION_ONE  = 16384;
    localparam int COEF_FRAC    = 14;
    localparam int TANGENT_FRAC = 4;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] kp;
        logic signed [COEF_BITS-1:0] km;
    } t_coef;

endpackage

### rtl/core/htb_in_if.sv
// ----------------------------------------------------------------------------
// htb_in_if
// Input channel: four-sample window, position and start flag.
// ----------------------------------------------------------------------------
interface htb_in_if #(
    parameter int SAMPLE_BITS   = 24,
    parameter int POSITION_BITS = 16
) ();
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   sample_a;
    logic signed [SAMPLE_BITS-1:0]   sample_b;
    logic signed [SAMPLE_BITS-1:0]   sample_c;
    logic signed [SAMPLE_BITS-1:0]   sample_d;
    logic        [POSITION_BITS-1:0] position;
    logic                            before_start;

    modport source (
        output valid, sample_a, sample_b, sample_c, sample_d, position, before_start,
        input  ready
    );
    modport sink (
        input  valid, sample_a, sample_b, sample_c, sample_d, position, before_start,
        output ready
    );
endinterface

### rtl/core/htb_out_if.sv
// ----------------------------------------------------------------------------
// htb_out_if
// Output channel: interpolated sample and saturation flag.
// ----------------------------------------------------------------------------
interface htb_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clipped;

    modport source (output valid, value, clipped, input ready);
    modport sink   (input valid, value, clipped, output ready);
endinterface

### rtl/core/htb_front.sv
// ----------------------------------------------------------------------------
// htb_front
// Accept a window, resolve the start case, form differences and mu^2.
// ----------------------------------------------------------------------------
module htb_front #(
    parameter int SAMPLE_BITS   = 24,
    parameter int POSITION_BITS = 16,
    parameter int ENTRY_BITS    = 3 * (SAMPLE_BITS + 1) + 2 * SAMPLE_BITS + 2 * POSITION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    htb_in_if.sink                i_in,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [ENTRY_BITS-1:0] o_push_data
);
    localparam int S  = SAMPLE_BITS;
    localparam int P  = POSITION_BITS;
    localparam int DW = S + 1;

    logic                   r_vld;
    logic signed [DW-1:0]   r_d0, r_d1, r_d2;
    logic signed [S-1:0]    r_y1, r_y2;
    logic        [P-1:0]    r_p, r_mu2;

    logic                   w_take;
    logic        [2*P-1:0]  w_sq;
    logic signed [DW-1:0]   w_d0;

    assign i_in.ready = !r_vld || i_push_ready;
    assign w_take     = i_in.valid && i_in.ready;

    // mu^2 rounded half up; the sum never carries past 2P bits
    assign w_sq = (2*P)'(i_in.position) * (2*P)'(i_in.position)
                + ((2*P)'(1) << (P - 1));

    // at the start of the array y0 = 2b - c, so y1 - y0 = c - b
    assign w_d0 = i_in.before_start ? (DW'(i_in.sample_c) - DW'(i_in.sample_b))
                                    : (DW'(i_in.sample_b) - DW'(i_in.sample_a));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_d0  <= w_d0;
            r_d1  <= DW'(i_in.sample_c) - DW'(i_in.sample_b);
            r_d2  <= DW'(i_in.sample_d) - DW'(i_in.sample_c);
            r_y1  <= i_in.sample_b;
            r_y2  <= i_in.sample_c;
            r_p   <= i_in.position;
            r_mu2 <= w_sq[2*P-1:P];
        end
    end

    assign o_push_valid = r_vld;
    assign o_push_data  = {r_d0, r_d1, r_d2, r_y1, r_y2, r_p, r_mu2};

endmodule

### rtl/core/htb_queue.sv
// ----------------------------------------------------------------------------
// htb_queue
// Small flop FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module htb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // wrap pointers at the depth
    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= n_wr;
            if (w_pop)  r_rd <= n_rd;
            if (w_push && !w_pop)      r_cnt <= r_cnt + CW'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_data;
    end

endmodule

### rtl/core/htb_back.sv
// ----------------------------------------------------------------------------
// htb_back
// Tangents, Hermite basis, weighted sum, rounding and saturation.
// ----------------------------------------------------------------------------
module htb_back #(
    parameter int SAMPLE_BITS   = 24,
    parameter int POSITION_BITS = 16,
    parameter int ENTRY_BITS    = 3 * (SAMPLE_BITS + 1) + 2 * SAMPLE_BITS + 2 * POSITION_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pop_valid,
    output logic                  o_pop_ready,
    input  logic [ENTRY_BITS-1:0] i_pop_data,
    input  htb_pkg::t_coef        i_coef,
    htb_out_if.source             o_out
);
    import htb_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int P    = POSITION_BITS;
    localparam int DW   = S + 1;
    localparam int PPW  = DW + COEF_BITS;
    localparam int TSUM = PPW + 1;
    localparam int TS   = COEF_FRAC - TANGENT_FRAC;
    localparam int MW   = TSUM - TS;
    localparam int HW   = P + 3;
    localparam int YPW  = HW + S;
    localparam int MPW  = HW + MW;
    localparam int AW   = MPW + 2;
    localparam int SH   = P + TANGENT_FRAC;
    localparam int RW   = AW + 1 - SH;

    localparam logic signed [TSUM-1:0] T_HALF = TSUM'(1) <<< (TS - 1);
    localparam logic signed [HW-1:0]   H_ONE  = HW'(1) <<< P;
    localparam logic signed [AW:0]     R_HALF = (AW + 1)'(1) <<< (SH - 1);
    localparam logic signed [RW-1:0]   SMAX   = (RW'(1) <<< (S - 1)) - RW'(1);
    localparam logic signed [RW-1:0]   SMIN   = -SMAX - RW'(1);

    logic adv;

    // unpacked queue head
    logic signed [DW-1:0] q_d0, q_d1, q_d2;
    logic signed [S-1:0]  q_y1, q_y2;
    logic        [P-1:0]  q_p, q_mu2;

    // stage 1: products
    logic                  r_s1_vld;
    logic signed [PPW-1:0] r_pp0, r_pp1, r_pp2, r_pp3;
    logic        [2*P-1:0] r_mu3raw;
    logic        [P-1:0]   r_s1_p, r_s1_mu2;
    logic signed [S-1:0]   r_s1_y1, r_s1_y2;

    // stage 2: tangents and basis
    logic                  r_s2_vld;
    logic signed [MW-1:0]  r_m0, r_m1;
    logic signed [HW-1:0]  r_h00, r_h10, r_h01, r_h11;
    logic signed [S-1:0]   r_s2_y1, r_s2_y2;

    // stage 3: weighted terms
    logic                  r_s3_vld;
    logic signed [YPW-1:0] r_t00, r_t11;
    logic signed [MPW-1:0] r_t10, r_t01;

    // stage 4: accumulated sum
    logic                  r_s4_vld;
    logic signed [AW-1:0]  r_acc;

    // output register
    logic                  r_out_vld;
    logic signed [S-1:0]   r_value;
    logic                  r_clip;

    logic signed [TSUM-1:0] w_tsum0, w_tsum1;
    logic        [2*P-1:0]  w_mu3sum;
    logic signed [HW-1:0]   w_mu, w_mu2, w_mu3;
    logic signed [AW:0]     w_rsum;
    logic signed [RW-1:0]   w_r;

    assign {q_d0, q_d1, q_d2, q_y1, q_y2, q_p, q_mu2} = i_pop_data;

    // whole pipeline moves unless the output register holds an untaken transaction
    assign adv         = !r_out_vld || o_out.ready;
    assign o_pop_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_pop_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pp0    <= q_d0 * i_coef.kp;
            r_pp1    <= q_d1 * i_coef.km;
            r_pp2    <= q_d1 * i_coef.kp;
            r_pp3    <= q_d2 * i_coef.km;
            r_mu3raw <= (2*P)'(q_mu2) * (2*P)'(q_p);
            r_s1_p   <= q_p;
            r_s1_mu2 <= q_mu2;
            r_s1_y1  <= q_y1;
            r_s1_y2  <= q_y2;
        end
    end

    // stage 2
    assign w_tsum0  = TSUM'(r_pp0) + TSUM'(r_pp1) + T_HALF;
    assign w_tsum1  = TSUM'(r_pp2) + TSUM'(r_pp3) + T_HALF;
    assign w_mu3sum = r_mu3raw + ((2*P)'(1) << (P - 1));
    assign w_mu     = $signed(HW'(r_s1_p));
    assign w_mu2    = $signed(HW'(r_s1_mu2));
    assign w_mu3    = $signed(HW'(w_mu3sum[2*P-1:P]));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m0    <= w_tsum0[TSUM-1:TS];
            r_m1    <= w_tsum1[TSUM-1:TS];
            r_h00   <= (w_mu3 <<< 1) - (w_mu2 <<< 1) - w_mu2 + H_ONE;
            r_h10   <= w_mu3 - (w_mu2 <<< 1) + w_mu;
            r_h01   <= w_mu3 - w_mu2;
            r_h11   <= (w_mu2 <<< 1) + w_mu2 - (w_mu3 <<< 1);
            r_s2_y1 <= r_s1_y1;
            r_s2_y2 <= r_s1_y2;
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t00 <= r_h00 * r_s2_y1;
            r_t11 <= r_h11 * r_s2_y2;
            r_t10 <= r_h10 * r_m0;
            r_t01 <= r_h01 * r_m1;
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_acc <= ((AW'(r_t00) + AW'(r_t11)) <<< TANGENT_FRAC)
                   + AW'(r_t10) + AW'(r_t01);
        end
    end

    // round half up, then saturate
    assign w_rsum = (AW + 1)'(r_acc) + R_HALF;
    assign w_r    = w_rsum[AW:SH];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            priority if (w_r > SMAX) begin
                r_value <= SMAX[S-1:0];
                r_clip  <= 1'b1;
            end else if (w_r < SMIN) begin
                r_value <= SMIN[S-1:0];
                r_clip  <= 1'b1;
            end else begin
                r_value <= w_r[S-1:0];
                r_clip  <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.value   = r_value;
    assign o_out.clipped = r_clip;

endmodule

### rtl/core/hermite_tension_bias_interp.sv
// ----------------------------------------------------------------------------
// hermite_tension_bias_interp
// Four-point cubic Hermite interpolator with tension and bias controls.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   sample_a..d, position, before_start
//  o_out     out  valid/ready   value, clipped
//  i_cfg_*   in   write enable  idx 0 tension, idx 1 bias (Q2.14)
//
//  One transaction per cycle in steady state while o_out.ready stays high. An
//  accepted input passes the front register, the queue and five back stages.
//  The front and back are split by a four-entry queue; the back pipeline
//  holds all stages while the output register waits on o_out.ready.
//  Synchronous active-low reset clears control state and both registers.
// ----------------------------------------------------------------------------
module hermite_tension_bias_interp #(
    parameter int SAMPLE_BITS   = htb_pkg::SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = htb_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    htb_in_if.sink                            i_in,
    htb_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [htb_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [htb_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import htb_pkg::*;

    localparam int EW = 3 * (SAMPLE_BITS + 1) + 2 * SAMPLE_BITS + 2 * POSITION_BITS;

    localparam logic signed [WEIGHT_BITS-1:0] W_ONE  = WEIGHT_BITS'(TENSION_ONE);
    localparam logic signed [COEF_PROD-1:0]   C_HALF = COEF_PROD'(1) <<< (COEF_SHIFT - 1);

    logic signed [CFG_DATA_BITS-1:0] r_tension, r_bias;
    t_coef                           r_coef;

    logic signed [WEIGHT_BITS-1:0] w_wt, w_bp, w_bm;
    logic signed [COEF_PROD-1:0]   w_kp, w_km;

    logic          w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    logic [EW-1:0] w_push_data, w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= '0;
            r_bias    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TENSION: r_tension <= i_cfg_data;
                CFG_BIAS:    r_bias    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // tangent weights (1 +- bias)(1 - tension)/2, rounded to Q14
    assign w_wt = W_ONE - WEIGHT_BITS'(r_tension);
    assign w_bp = W_ONE + WEIGHT_BITS'(r_bias);
    assign w_bm = W_ONE - WEIGHT_BITS'(r_bias);
    assign w_kp = w_bp * w_wt + C_HALF;
    assign w_km = w_bm * w_wt + C_HALF;

    always_ff @(posedge i_clk) begin
        r_coef.kp <= w_kp[COEF_SHIFT+COEF_BITS-1:COEF_SHIFT];
        r_coef.km <= w_km[COEF_SHIFT+COEF_BITS-1:COEF_SHIFT];
    end

    htb_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .POSITION_BITS(POSITION_BITS),
        .ENTRY_BITS   (EW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_push_valid(w_push_valid),
        .i_push_ready(w_push_ready),
        .o_push_data (w_push_data)
    );

    htb_queue #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(w_push_valid),
        .o_push_ready(w_push_ready),
        .i_push_data (w_push_data),
        .o_pop_valid (w_pop_valid),
        .i_pop_ready (w_pop_ready),
        .o_pop_data  (w_pop_data)
    );

    htb_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .POSITION_BITS(POSITION_BITS),
        .ENTRY_BITS   (EW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_valid(w_pop_valid),
        .o_pop_ready(w_pop_ready),
        .i_pop_data (w_pop_data),
        .i_coef     (r_coef),
        .o_out      (o_out)
    );

endmodule
